// ===== hdl/knn4_pkg.sv =====
// Shared types, widths and codes for the four-nearest-neighbor weighting block.
package knn4_pkg;

  // Sizing
  localparam int MAX_JOINTS = 1024;
  localparam int COORD_BITS = 24;
  localparam int KEEP       = 4;
  localparam int IDX_W      = $clog2(MAX_JOINTS);
  localparam int CNT_W      = $clog2(MAX_JOINTS + 1);
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int RT_W       = DIFF_W;
  localparam int OFF_W      = 16;
  localparam int E_W        = ((RT_W > OFF_W) ? RT_W : OFF_W) + 1;
  localparam int E2_W       = 2 * E_W;
  localparam int INV_W      = 61;
  localparam int SUM_W      = INV_W + 2;
  localparam int WGT_W      = 16;
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int STEP_W     = $clog2(INV_W);
  localparam int JOINT_W    = 3 * COORD_BITS;

  // Configuration port
  localparam int          ADDR_W       = 3;
  localparam int          DATA_W       = 32;
  localparam logic        REG_SMOOTH   = 1'b0;
  localparam logic [15:0] OFFSET_RESET = 16'd51;

  // Function codes
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;
  localparam logic [1:0] FUNC_NOP    = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]                   func;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
  } knn4_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] near_index_0;
    logic [IDX_W-1:0] near_index_1;
    logic [IDX_W-1:0] near_index_2;
    logic [IDX_W-1:0] near_index_3;
    logic [WGT_W-1:0] weight_0;
    logic [WGT_W-1:0] weight_1;
    logic [WGT_W-1:0] weight_2;
    logic [WGT_W-1:0] weight_3;
  } knn4_out_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } knn4_joint_t;

  // One scored candidate leaving the distance pipeline
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic [SQ_W-1:0]  sq;
  } knn4_cand_t;

  // Current best four, nearest first
  typedef struct packed {
    logic [2:0]                  cnt;
    logic [KEEP-1:0][SQ_W-1:0]   key;
    logic [KEEP-1:0][IDX_W-1:0]  idx;
  } knn4_rank_t;

  // Weight unit result
  typedef struct packed {
    logic                        done;
    logic [KEEP-1:0][WGT_W-1:0]  wgt;
  } knn4_wres_t;

endpackage

// ===== hdl/knn4_inverse_distance_weights.sv =====
// Top level: joint store, scan control, configuration port and result register.
//
//  channel   signals                          transfer
//  in        in_valid/in_ready/in_data        valid & ready at rising edge
//  out       out_valid/out_ready/out_data     valid & ready at rising edge
//  cfg       psel/penable/pwrite/paddr/...    psel & penable & pwrite, no wait
//
// Clear, append and no-op items go straight to the result stage. After acceptance
// a query scans N stored joints (one joint store read per cycle), drains the
// distance pipeline, then the weight unit takes each kept joint in turn, forms
// the normalizing fractions and the result is handed over.
// Reset is synchronous and needs no clearing pass. One item is in work at a
// time; a stalled result holds in the output register while the next item is
// already accepted, and that next result waits until the first is taken.
module knn4_inverse_distance_weights (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  knn4_pkg::knn4_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output knn4_pkg::knn4_out_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [knn4_pkg::ADDR_W-1:0] paddr,
  input  logic [knn4_pkg::DATA_W-1:0] pwdata,
  output logic [knn4_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_WGT   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [1:0] DRAIN_LAST = 2'd3;

  localparam int IW = knn4_pkg::IDX_W;
  localparam int CW = knn4_pkg::CNT_W;

  logic [2:0]                   state_r;
  logic [CW-1:0]                count_r, scan_r;
  logic [knn4_pkg::OFF_W-1:0]   off_r;
  knn4_pkg::knn4_joint_t        query_r;
  logic                         p0_valid_r;
  logic [IW-1:0]                p0_idx_r;
  logic [1:0]                   drain_r;
  knn4_pkg::knn4_out_t          res_r, out_r;
  knn4_pkg::knn4_out_t          acc_res;
  logic                         out_valid_r;

  logic                         in_acc, ram_we, issue, wgt_start, emit, cfg_wr;
  knn4_pkg::knn4_joint_t        wjoint, rjoint;
  knn4_pkg::knn4_cand_t         cand;
  knn4_pkg::knn4_rank_t         rank;
  knn4_pkg::knn4_wres_t         wres;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign ram_we    = in_acc && (in_data.func == knn4_pkg::FUNC_APPEND) &&
                     (count_r != CW'(knn4_pkg::MAX_JOINTS));
  assign issue     = (state_r == S_SCAN) && (scan_r < count_r);
  assign wgt_start = (state_r == S_DRAIN) && (drain_r == DRAIN_LAST);
  assign emit      = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  assign wjoint.x = in_data.coord_x;
  assign wjoint.y = in_data.coord_y;
  assign wjoint.z = in_data.coord_z;

  // joint store
  knn4_ram #(
    .WIDTH (knn4_pkg::JOINT_W),
    .DEPTH (knn4_pkg::MAX_JOINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IW-1:0]),
    .wdata (wjoint),
    .raddr (scan_r[IW-1:0]),
    .rdata (rjoint)
  );

  knn4_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (p0_valid_r),
    .in_idx   (p0_idx_r),
    .joint    (rjoint),
    .query    (query_r),
    .cand     (cand)
  );

  knn4_rank u_rank (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (in_acc && (in_data.func == knn4_pkg::FUNC_QUERY)),
    .cand  (cand),
    .rank  (rank)
  );

  knn4_wgt u_wgt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (wgt_start),
    .rank   (rank),
    .offset (off_r),
    .wres   (wres)
  );

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[knn4_pkg::ADDR_W-1] == knn4_pkg::REG_SMOOTH) ?
                  knn4_pkg::DATA_W'(off_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= knn4_pkg::OFFSET_RESET;
    end else if (cfg_wr && (paddr[knn4_pkg::ADDR_W-1] == knn4_pkg::REG_SMOOTH)) begin
      off_r <= pwdata[knn4_pkg::OFF_W-1:0];
    end
  end

  // item sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      scan_r     <= '0;
      p0_valid_r <= 1'b0;
      drain_r    <= '0;
    end else begin
      p0_valid_r <= issue;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_data.func)
              knn4_pkg::FUNC_CLEAR: begin
                count_r <= '0;
                state_r <= S_EMIT;
              end
              knn4_pkg::FUNC_APPEND: begin
                if (ram_we) begin
                  count_r <= count_r + 1'b1;
                end
                state_r <= S_EMIT;
              end
              knn4_pkg::FUNC_QUERY: begin
                scan_r  <= '0;
                state_r <= S_SCAN;
              end
              knn4_pkg::FUNC_NOP: state_r <= S_EMIT;
              default: state_r <= S_EMIT;
            endcase
          end
        end
        S_SCAN: begin
          if (issue) begin
            scan_r <= scan_r + 1'b1;
          end else begin
            drain_r <= '0;
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          drain_r <= drain_r + 1'b1;
          if (wgt_start) state_r <= S_WGT;
        end
        S_WGT:  if (wres.done) state_r <= S_EMIT;
        S_EMIT: if (emit) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result of a request that needs no scan
  always_comb begin
    acc_res = '0;
    if ((in_data.func == knn4_pkg::FUNC_APPEND) && !ram_we) begin
      acc_res.status = knn4_pkg::ST_FULL;
    end
  end

  // query point, scan index and staged result
  always_ff @(posedge clk) begin
    p0_idx_r <= scan_r[IW-1:0];
    if (in_acc) begin
      query_r <= wjoint;
      res_r   <= acc_res;
    end else if ((state_r == S_WGT) && wres.done) begin
      res_r.status       <= (rank.cnt < 3'(knn4_pkg::KEEP)) ? knn4_pkg::ST_FEW : knn4_pkg::ST_OK;
      res_r.near_index_0 <= rank.idx[0];
      res_r.near_index_1 <= rank.idx[1];
      res_r.near_index_2 <= rank.idx[2];
      res_r.near_index_3 <= rank.idx[3];
      res_r.weight_0     <= wres.wgt[0];
      res_r.weight_1     <= wres.wgt[1];
      res_r.weight_2     <= wres.wgt[2];
      res_r.weight_3     <= wres.wgt[3];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/knn4_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module knn4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/knn4_dist.sv =====
// Three-stage squared-distance pipeline: differences, squares, sum.
module knn4_dist (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [knn4_pkg::IDX_W-1:0] in_idx,
  input  knn4_pkg::knn4_joint_t      joint,
  input  knn4_pkg::knn4_joint_t      query,
  output knn4_pkg::knn4_cand_t       cand
);

  localparam int DW = knn4_pkg::DIFF_W;

  logic                       v1_r, v2_r, v3_r;
  logic [knn4_pkg::IDX_W-1:0] i1_r, i2_r, i3_r;
  logic [DW-1:0]              dx_r, dy_r, dz_r;
  logic [2*DW-1:0]            sx_r, sy_r, sz_r;
  logic [knn4_pkg::SQ_W-1:0]  sq_r;
  logic signed [DW-1:0]       ex, ey, ez;

  // signed differences, one bit wider than the coordinates
  always_comb begin
    ex = DW'(joint.x) - DW'(query.x);
    ey = DW'(joint.y) - DW'(query.y);
    ez = DW'(joint.z) - DW'(query.z);
  end

  // valid tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    i1_r <= in_idx;
    dx_r <= ex[DW-1] ? DW'(-ex) : DW'(ex);
    dy_r <= ey[DW-1] ? DW'(-ey) : DW'(ey);
    dz_r <= ez[DW-1] ? DW'(-ez) : DW'(ez);
    i2_r <= i1_r;
    sx_r <= dx_r * dx_r;
    sy_r <= dy_r * dy_r;
    sz_r <= dz_r * dz_r;
    i3_r <= i2_r;
    sq_r <= knn4_pkg::SQ_W'(sx_r + sy_r + sz_r);
  end

  assign cand.valid = v3_r;
  assign cand.idx   = i3_r;
  assign cand.sq    = sq_r;

endmodule

// ===== hdl/knn4_rank.sv =====
// Sorted list of the four nearest candidates, updated by insertion.
module knn4_rank (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clr,
  input  knn4_pkg::knn4_cand_t cand,
  output knn4_pkg::knn4_rank_t rank
);

  localparam int K = knn4_pkg::KEEP;

  logic [2:0]                            cnt_r, cnt_nxt;
  logic [K-1:0][knn4_pkg::SQ_W-1:0]      key_r, key_nxt;
  logic [K-1:0][knn4_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic [2:0]                            pos;
  logic                                  enter;

  // insertion point: new entry goes ahead of equal keys
  always_comb begin
    pos   = 3'd0;
    enter = cand.valid && ((cnt_r < 3'(K)) || (cand.sq < key_r[K-1]));
    for (int m = 0; m < K; m++) begin
      if ((3'(m) < cnt_r) && (key_r[m] < cand.sq)) begin
        pos = pos + 3'd1;
      end
    end
    key_nxt = key_r;
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    if (enter) begin
      for (int m = 0; m < K; m++) begin
        if (3'(m) == pos) begin
          key_nxt[m] = cand.sq;
          idx_nxt[m] = cand.idx;
        end else if (3'(m) > pos) begin
          key_nxt[m] = key_r[(m == 0) ? 0 : m - 1];
          idx_nxt[m] = idx_r[(m == 0) ? 0 : m - 1];
        end
      end
      if (cnt_r < 3'(K)) begin
        cnt_nxt = cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      cnt_r <= 3'd0;
      key_r <= '0;
      idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      key_r <= key_nxt;
      idx_r <= idx_nxt;
    end
  end

  assign rank.cnt = cnt_r;
  assign rank.key = key_r;
  assign rank.idx = idx_r;

endmodule

// ===== hdl/knn4_wgt.sv =====
// Sequential weight unit: root, inverse square, sum and normalizing fraction.
module knn4_wgt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  knn4_pkg::knn4_rank_t        rank,
  input  logic [knn4_pkg::OFF_W-1:0]  offset,
  output knn4_pkg::knn4_wres_t        wres
);

  localparam int K    = knn4_pkg::KEEP;
  localparam int SQW  = knn4_pkg::SQ_W;
  localparam int EW   = knn4_pkg::E_W;
  localparam int E2W  = knn4_pkg::E2_W;
  localparam int IW   = knn4_pkg::INV_W;
  localparam int SW   = knn4_pkg::SUM_W;
  localparam int FW   = knn4_pkg::SUM_W + 1;
  localparam int WW   = knn4_pkg::WGT_W;
  localparam int STW  = knn4_pkg::STEP_W;

  localparam logic [3:0] W_IDLE = 4'd0;
  localparam logic [3:0] W_LOAD = 4'd1;
  localparam logic [3:0] W_SQRT = 4'd2;
  localparam logic [3:0] W_E    = 4'd3;
  localparam logic [3:0] W_SQ   = 4'd4;
  localparam logic [3:0] W_DIV  = 4'd5;
  localparam logic [3:0] W_ACC  = 4'd6;
  localparam logic [3:0] W_FRAC = 4'd7;
  localparam logic [3:0] W_FDIV = 4'd8;
  localparam logic [3:0] W_DONE = 4'd9;

  logic [3:0]                  state_r;
  logic [2:0]                  k_r, cnt_r;
  logic [STW-1:0]              step_r;
  logic [K-1:0][SQW-1:0]       key_r;
  logic [knn4_pkg::OFF_W-1:0]  off_r;
  logic [SQW-1:0]              n_r, res_r, bit_r;
  logic [EW-1:0]               e_r;
  logic [E2W-1:0]              e2_r, rem_r;
  logic [IW-1:0]               q_r;
  logic [K-1:0][IW-1:0]        inv_r;
  logic [SW-1:0]               sum_r;
  logic [FW-1:0]               frem_r;
  logic [WW-1:0]               fq_r;
  logic [K-1:0][WW-1:0]        wgt_r;
  logic                        done_r;

  logic [SQW:0]                trial;
  logic [E2W:0]                rem_sh;
  logic [E2W-1:0]              e2_full;
  logic [FW-1:0]               frem_sh;
  logic [FW-1:0]               sum_ext;

  always_comb begin
    trial   = {1'b0, res_r} + {1'b0, bit_r};
    rem_sh  = {rem_r, (step_r == '0)};
    e2_full = e_r * e_r;
    frem_sh = {frem_r[FW-2:0], 1'b0};
    sum_ext = FW'(sum_r);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= W_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        W_IDLE: if (start) state_r <= W_LOAD;
        W_LOAD: state_r <= (k_r == cnt_r) ? W_FRAC : W_SQRT;
        W_SQRT: if (step_r == STW'(knn4_pkg::SQRT_STEPS - 1)) state_r <= W_E;
        W_E:    state_r <= W_SQ;
        W_SQ:   state_r <= W_DIV;
        W_DIV:  if (step_r == STW'(IW - 1)) state_r <= W_ACC;
        W_ACC:  state_r <= W_LOAD;
        W_FRAC: begin
          if (k_r == 3'(K)) begin
            state_r <= W_DONE;
          end else if ((k_r < cnt_r) && (sum_r != '0) && (SW'(inv_r[k_r[1:0]]) < sum_r)) begin
            state_r <= W_FDIV;
          end
        end
        W_FDIV: if (step_r == STW'(WW - 1)) state_r <= W_FRAC;
        W_DONE: begin
          done_r  <= 1'b1;
          state_r <= W_IDLE;
        end
        default: state_r <= W_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      W_IDLE: begin
        cnt_r <= rank.cnt;
        key_r <= rank.key;
        off_r <= offset;
        k_r   <= 3'd0;
        sum_r <= '0;
      end
      W_LOAD: begin
        if (k_r == cnt_r) begin
          k_r <= 3'd0;
        end
        n_r    <= key_r[k_r[1:0]];
        res_r  <= '0;
        bit_r  <= SQW'(1) << (2 * (knn4_pkg::SQRT_STEPS - 1));
        step_r <= '0;
      end
      // one root digit per cycle
      W_SQRT: begin
        if ({1'b0, n_r} >= trial) begin
          n_r   <= n_r - trial[SQW-1:0];
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r  <= bit_r >> 2;
        step_r <= step_r + 1'b1;
      end
      W_E: e_r <= EW'(res_r[knn4_pkg::RT_W-1:0]) + EW'(off_r);
      W_SQ: begin
        e2_r   <= (e2_full == '0) ? E2W'(1) : e2_full;
        rem_r  <= '0;
        q_r    <= '0;
        step_r <= '0;
      end
      // restoring division of 2^60 by e^2, one quotient bit per cycle
      W_DIV: begin
        if (rem_sh >= {1'b0, e2_r}) begin
          rem_r <= E2W'(rem_sh - {1'b0, e2_r});
          q_r   <= {q_r[IW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[E2W-1:0];
          q_r   <= {q_r[IW-2:0], 1'b0};
        end
        step_r <= step_r + 1'b1;
      end
      W_ACC: begin
        inv_r[k_r[1:0]] <= q_r;
        sum_r           <= sum_r + SW'(q_r);
        k_r             <= k_r + 3'd1;
      end
      // pick the weight for slot k, or start its fraction
      W_FRAC: begin
        if (k_r != 3'(K)) begin
          frem_r <= FW'(inv_r[k_r[1:0]]);
          fq_r   <= '0;
          step_r <= '0;
          if ((k_r >= cnt_r) || (sum_r == '0)) begin
            wgt_r[k_r[1:0]] <= '0;
            k_r             <= k_r + 3'd1;
          end else if (SW'(inv_r[k_r[1:0]]) >= sum_r) begin
            wgt_r[k_r[1:0]] <= '1;
            k_r             <= k_r + 3'd1;
          end
        end
      end
      W_FDIV: begin
        if (frem_sh >= sum_ext) begin
          frem_r <= frem_sh - sum_ext;
          fq_r   <= {fq_r[WW-2:0], 1'b1};
        end else begin
          frem_r <= frem_sh;
          fq_r   <= {fq_r[WW-2:0], 1'b0};
        end
        step_r <= step_r + 1'b1;
        if (step_r == STW'(WW - 1)) begin
          wgt_r[k_r[1:0]] <= {fq_r[WW-2:0], (frem_sh >= sum_ext)};
          k_r             <= k_r + 3'd1;
        end
      end
      default: ;
    endcase
  end

  assign wres.done = done_r;
  assign wres.wgt  = wgt_r;

endmodule
